// ===== rtl/rrwl_pkg.sv =====
// Shared request and status codes for the recursive reader-writer lock.
package rrwl_pkg;

	// request kinds
	localparam logic [2:0] K_LOCK          = 3'd0;
	localparam logic [2:0] K_TRY_LOCK      = 3'd1;
	localparam logic [2:0] K_UNLOCK        = 3'd2;
	localparam logic [2:0] K_LOCK_SHARED   = 3'd3;
	localparam logic [2:0] K_TRY_SHARED    = 3'd4;
	localparam logic [2:0] K_UNLOCK_SHARED = 3'd5;

	// result status codes
	localparam logic [1:0] ST_GRANTED = 2'd0;
	localparam logic [1:0] ST_REFUSED = 2'd1;
	localparam logic [1:0] ST_WAIT    = 2'd2;
	localparam logic [1:0] ST_ERROR   = 2'd3;

	// request fields as latched for the execute cycle
	typedef struct packed {
		logic [2:0] kind;
		logic [3:0] thread_id;
		logic       bad;
	} rrwl_req_t;

endpackage

// ===== rtl/recursive_reader_writer_lock.sv =====
// Top level of the recursive reader-writer lock manager.
//
// Requests arrive on the in channel (in_valid/in_ready) as a kind and a
// thread id; each request yields exactly one result on the out channel
// (out_valid/out_ready): a status, the write depth, the requester's shared
// count and the number of threads holding shared locks.
// The accept edge reads the thread's entry from the count table into the
// table's read register; the execute state then applies the update, writes
// the entry back and loads the result register once that register is free.
// One request is in progress at a time, as the table reads and then writes
// back one entry. A new request is taken while the previous result still
// waits; if the receiver stalls, the second request holds in its execute
// cycle until the result register frees. The recursion limit is written
// through cfg_wr_en/cfg_wr_data while idle; the user must keep to this, as
// the block itself does not enforce it. Reset clears the lock state at once:
// all counts read as zero, there is no owner and the limit is 65535.
module recursive_reader_writer_lock import rrwl_pkg::*; #(
	parameter int THREADS    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wr_en,
	input  logic [15:0] cfg_wr_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [3:0]  thread_id,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  status,
	output logic [15:0] write_depth,
	output logic [15:0] shared_depth,
	output logic [4:0]  readers_active
);

	localparam int AW = $clog2(THREADS);
	localparam int OW = $clog2(THREADS+1);
	localparam int RW = $clog2(THREADS+1);
	localparam int IW = (AW > 4) ? AW : 4;
	localparam int CB = COUNT_BITS;

	localparam logic S_IDLE = 1'b0;
	localparam logic S_EXEC = 1'b1;

	logic              state_q;
	logic [15:0]       limit_q;
	logic [CB-1:0]     wc_q;
	logic [OW-1:0]     owner_q;
	logic              ww_q;
	logic [RW-1:0]     rt_q;
	rrwl_req_t         req_s1;
	logic [AW-1:0]     addr_s1;

	logic [1:0]        status_q;
	logic [15:0]       wdepth_q;
	logic [15:0]       sdepth_q;
	logic [4:0]        readers_q;
	logic              out_valid_q;

	logic              accept;
	logic              fire;
	logic [IW-1:0]     tid_w;
	logic [AW-1:0]     addr;
	logic [2*CB-1:0]   rd_entry;
	logic [CB-1:0]     sc_n;
	logic [CB-1:0]     pc_n;
	logic [CB-1:0]     wc_n;
	logic [OW-1:0]     owner_n;
	logic              ww_n;
	logic [RW-1:0]     rt_n;
	logic [1:0]        status_n;
	logic [31:0]       wc_wide;
	logic [31:0]       sc_wide;
	logic [31:0]       rt_wide;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign fire     = (state_q == S_EXEC) && (!out_valid_q || out_ready);
	assign tid_w    = IW'(thread_id);
	assign addr     = tid_w[AW-1:0];

	rrwl_table #(
		.THREADS    (THREADS),
		.COUNT_BITS (COUNT_BITS)
	) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (addr),
		.rd_data (rd_entry),
		.wr_en   (fire && !req_s1.bad),
		.wr_addr (addr_s1),
		.wr_data ({sc_n, pc_n})
	);

	rrwl_core #(
		.THREADS    (THREADS),
		.COUNT_BITS (COUNT_BITS)
	) u_core (
		.req     (req_s1),
		.limit   (limit_q),
		.sc      (rd_entry[2*CB-1:CB]),
		.pc      (rd_entry[CB-1:0]),
		.wc      (wc_q),
		.owner   (owner_q),
		.ww      (ww_q),
		.rt      (rt_q),
		.sc_n    (sc_n),
		.pc_n    (pc_n),
		.wc_n    (wc_n),
		.owner_n (owner_n),
		.ww_n    (ww_n),
		.rt_n    (rt_n),
		.status  (status_n)
	);

	// latch the request for its execute cycle
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1.kind      <= kind;
			req_s1.thread_id <= thread_id;
			req_s1.bad       <= (32'(thread_id) >= THREADS) || (kind > K_UNLOCK_SHARED);
			addr_s1          <= addr;
		end
	end

	// sequence read and write-back
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else if (accept) begin
			state_q <= S_EXEC;
		end else if (fire) begin
			state_q <= S_IDLE;
		end
	end

	// hold the recursion limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= 16'hFFFF;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// advance the global lock state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wc_q    <= '0;
			owner_q <= OW'(THREADS);
			ww_q    <= 1'b0;
			rt_q    <= '0;
		end else if (fire) begin
			wc_q    <= wc_n;
			owner_q <= owner_n;
			ww_q    <= ww_n;
			rt_q    <= rt_n;
		end
	end

	// report zero shared depth only for a thread outside the table
	assign wc_wide = 32'(wc_n);
	assign sc_wide = (32'(req_s1.thread_id) >= THREADS) ? 32'd0 : 32'(sc_n);
	assign rt_wide = 32'(rt_n);

	// load the result register, drop it when taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q  <= status_n;
			wdepth_q  <= wc_wide[15:0];
			sdepth_q  <= sc_wide[15:0];
			readers_q <= rt_wide[4:0];
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign write_depth    = wdepth_q;
	assign shared_depth   = sdepth_q;
	assign readers_active = readers_q;

endmodule

// ===== rtl/rrwl_table.sv =====
// Per-thread shared and parked count memory with per-entry valid bits.
module rrwl_table import rrwl_pkg::*; #(
	parameter int THREADS    = 16,
	parameter int COUNT_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          rd_en,
	input  logic [$clog2(THREADS)-1:0]    rd_addr,
	output logic [2*COUNT_BITS-1:0]       rd_data,
	input  logic                          wr_en,
	input  logic [$clog2(THREADS)-1:0]    wr_addr,
	input  logic [2*COUNT_BITS-1:0]       wr_data
);

	logic [2*COUNT_BITS-1:0] mem [THREADS];
	logic [THREADS-1:0]      valid_q;
	logic [2*COUNT_BITS-1:0] data_s1;
	logic                    vld_s1;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// mark written entries; unwritten ones read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wr_en) begin
			valid_q[wr_addr] <= 1'b1;
		end
	end

	// registered read port, held between reads
	always_ff @(posedge clk) begin
		if (rd_en) begin
			data_s1 <= mem[rd_addr];
			vld_s1  <= valid_q[rd_addr];
		end
	end

	assign rd_data = vld_s1 ? data_s1 : '0;

endmodule

// ===== rtl/rrwl_core.sv =====
// Next-state logic of the lock for one request.
module rrwl_core import rrwl_pkg::*; #(
	parameter int THREADS    = 16,
	parameter int COUNT_BITS = 16
) (
	input  rrwl_req_t                        req,
	input  logic [15:0]                      limit,
	input  logic [COUNT_BITS-1:0]            sc,
	input  logic [COUNT_BITS-1:0]            pc,
	input  logic [COUNT_BITS-1:0]            wc,
	input  logic [$clog2(THREADS+1)-1:0]     owner,
	input  logic                             ww,
	input  logic [$clog2(THREADS+1)-1:0]     rt,
	output logic [COUNT_BITS-1:0]            sc_n,
	output logic [COUNT_BITS-1:0]            pc_n,
	output logic [COUNT_BITS-1:0]            wc_n,
	output logic [$clog2(THREADS+1)-1:0]     owner_n,
	output logic                             ww_n,
	output logic [$clog2(THREADS+1)-1:0]     rt_n,
	output logic [1:0]                       status
);

	localparam int OW = $clog2(THREADS+1);
	localparam logic [OW-1:0] NO_OWNER = OW'(THREADS);
	localparam logic [COUNT_BITS-1:0] CMAX = '1;

	logic [OW-1:0] tid_o;
	logic          is_owner;
	logic          nest_ok;
	logic          no_owner;

	function automatic logic [COUNT_BITS-1:0] sat_add(
		input logic [COUNT_BITS-1:0] a,
		input logic [COUNT_BITS-1:0] b
	);
		logic [COUNT_BITS:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[COUNT_BITS] ? CMAX : s[COUNT_BITS-1:0];
	endfunction

	assign tid_o    = OW'(req.thread_id);
	assign is_owner = (owner == tid_o);
	assign no_owner = (owner == NO_OWNER);
	assign nest_ok  = (33'(wc) < 33'(limit)) && (wc != CMAX);

	// decode the request against the lock state
	always_comb begin
		sc_n    = sc;
		pc_n    = pc;
		wc_n    = wc;
		owner_n = owner;
		ww_n    = ww;
		rt_n    = rt;
		status  = ST_ERROR;
		if (!req.bad) begin
			case (req.kind)
				K_LOCK: begin
					if (is_owner) begin
						if (nest_ok) begin
							wc_n   = wc + 1'b1;
							status = ST_GRANTED;
						end
					end else begin
						// park own shared holds
						if (sc != '0) begin
							pc_n = sat_add(pc, sc);
							sc_n = '0;
							rt_n = rt - 1'b1;
						end
						if (!no_owner) begin
							status = ST_WAIT;
						end else if (rt_n != '0) begin
							ww_n   = 1'b1;
							status = ST_WAIT;
						end else begin
							owner_n = tid_o;
							wc_n    = COUNT_BITS'(1);
							ww_n    = 1'b0;
							status  = ST_GRANTED;
						end
					end
				end
				K_TRY_LOCK: begin
					if (is_owner) begin
						if (nest_ok) begin
							wc_n   = wc + 1'b1;
							status = ST_GRANTED;
						end
					end else if (no_owner && rt == '0) begin
						owner_n = tid_o;
						wc_n    = COUNT_BITS'(1);
						ww_n    = 1'b0;
						status  = ST_GRANTED;
					end else begin
						status = ST_REFUSED;
					end
				end
				K_LOCK_SHARED, K_TRY_SHARED: begin
					if (is_owner) begin
						if (nest_ok) begin
							wc_n   = wc + 1'b1;
							status = ST_GRANTED;
						end
					end else if (!no_owner || ww) begin
						status = (req.kind == K_LOCK_SHARED) ? ST_WAIT : ST_REFUSED;
					end else if (sc != CMAX) begin
						if (sc == '0) begin
							rt_n = rt + 1'b1;
						end
						sc_n   = sc + 1'b1;
						status = ST_GRANTED;
					end
				end
				K_UNLOCK, K_UNLOCK_SHARED: begin
					if (is_owner) begin
						// write release; restore parked holds at depth zero
						if (wc != '0) begin
							wc_n   = wc - 1'b1;
							status = ST_GRANTED;
							if (wc == COUNT_BITS'(1)) begin
								if (pc != '0) begin
									if (sc == '0) begin
										rt_n = rt + 1'b1;
									end
									sc_n = sat_add(sc, pc);
									pc_n = '0;
								end
								owner_n = NO_OWNER;
							end
						end
					end else if (req.kind == K_UNLOCK_SHARED && sc != '0) begin
						sc_n = sc - 1'b1;
						if (sc == COUNT_BITS'(1)) begin
							rt_n = rt - 1'b1;
						end
						status = ST_GRANTED;
					end
				end
				default: begin
					status = ST_ERROR;
				end
			endcase
		end
	end

endmodule

// ===== rtl/rrwl_checker.sv =====
// Port-level checker for the recursive reader-writer lock, bound to the top level.
module rrwl_checker import rrwl_pkg::*; #(
	parameter int THREADS = 16
) (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic [1:0]  status,
	input logic [15:0] write_depth,
	input logic [4:0]  readers_active
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(write_depth)
		&& $stable(readers_active))
		else $error("stalled result changed");

	// one request at a time: busy in the cycle after an accept
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while busy");

	// reader count never exceeds the thread count
	a_readers: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> 32'(readers_active) <= THREADS)
		else $error("reader count out of range");

endmodule

bind recursive_reader_writer_lock rrwl_checker #(
	.THREADS (THREADS)
) u_rrwl_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (in_valid),
	.in_ready       (in_ready),
	.out_valid      (out_valid),
	.out_ready      (out_ready),
	.status         (status),
	.write_depth    (write_depth),
	.readers_active (readers_active)
);

// ===== bench/recursive_reader_writer_lock_tb.sv =====
// Self-checking testbench for the recursive reader-writer lock manager.
module recursive_reader_writer_lock_tb;
	import rrwl_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [4:0] NO_OWNER     = 5'd16;
	localparam logic [2:0] K_RESERVED_6 = 3'd6;
	localparam logic [2:0] K_RESERVED_7 = 3'd7;
	localparam int         CYCLE_LIMIT  = 4000000;
	localparam int         ERROR_PRINTS = 40;
	localparam int         NEST_RUN     = 24;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] wdepth;
		logic [15:0] sdepth;
		logic [4:0]  readers;
	} lock_reply_t;

	logic        clk            = 1'b0;
	logic        arst_n         = 1'b0;
	logic        cfg_wr_en      = 1'b0;
	logic [15:0] cfg_wr_data    = '0;
	logic        in_valid       = 1'b0;
	logic        in_ready;
	logic [2:0]  kind           = '0;
	logic [3:0]  thread_id      = '0;
	logic        out_valid;
	logic        out_ready      = 1'b0;
	logic [1:0]  status;
	logic [15:0] write_depth;
	logic [15:0] shared_depth;
	logic [4:0]  readers_active;

	// lock state as the testbench expects it
	logic [15:0] sh_cnt [16];
	logic [15:0] pk_cnt [16];
	logic [15:0] wr_cnt     = '0;
	logic [4:0]  owner_id   = NO_OWNER;
	logic        wr_pending = 1'b0;
	logic [4:0]  reader_cnt = '0;
	logic [15:0] rec_limit  = 16'hFFFF;

	lock_reply_t lock_replies_q [$];
	int          mismatch_cnt = 0;
	int          cycle_cnt    = 0;

	// traffic shaping
	bit tx_quiet     = 1'b0;
	bit rx_quiet     = 1'b0;
	int burst_left   = 0;
	int rx_hold_left = 0;
	int rx_seg_left  = 0;
	int rx_mode      = 0;

	recursive_reader_writer_lock dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_wr_data    (cfg_wr_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.thread_id      (thread_id),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.status         (status),
		.write_depth    (write_depth),
		.shared_depth   (shared_depth),
		.readers_active (readers_active)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		for (int i = 0; i < 16; i++) begin
			sh_cnt[i] = '0;
			pk_cnt[i] = '0;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [15:0] sat_sum(input logic [15:0] a, input logic [15:0] b);
		logic [16:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[16] ? 16'hFFFF : s[15:0];
	endfunction

	// deepen the owner's write hold, bounded by the limit and the counter
	function automatic logic [1:0] nest_write_hold();
		if (wr_cnt < rec_limit && wr_cnt != 16'hFFFF) begin
			wr_cnt++;
			return ST_GRANTED;
		end
		return ST_ERROR;
	endfunction

	// drop one write hold; on the last one hand back the parked shared holds
	function automatic logic [1:0] release_write_hold(input logic [3:0] t);
		if (owner_id != {1'b0, t} || wr_cnt == 0)
			return ST_ERROR;
		wr_cnt--;
		if (wr_cnt == 0) begin
			if (pk_cnt[t] != 0) begin
				if (sh_cnt[t] == 0)
					reader_cnt++;
				sh_cnt[t] = sat_sum(sh_cnt[t], pk_cnt[t]);
				pk_cnt[t] = '0;
			end
			owner_id = NO_OWNER;
		end
		return ST_GRANTED;
	endfunction

	function automatic logic [1:0] take_shared_hold(input logic [3:0] t, input bit blocking);
		if (owner_id == {1'b0, t})
			return nest_write_hold();
		if (owner_id != NO_OWNER || wr_pending)
			return blocking ? ST_WAIT : ST_REFUSED;
		if (sh_cnt[t] == 16'hFFFF)
			return ST_ERROR;
		if (sh_cnt[t] == 0)
			reader_cnt++;
		sh_cnt[t]++;
		return ST_GRANTED;
	endfunction

	function automatic lock_reply_t predict_lock_reply(input logic [2:0] req_kind,
			input logic [3:0] req_tid);
		lock_reply_t r;
		logic [1:0]  st;
		logic [4:0]  tid5;
		tid5 = {1'b0, req_tid};
		if (req_kind > K_UNLOCK_SHARED) begin
			st = ST_ERROR;
		end else begin
			case (req_kind)
				K_LOCK: begin
					if (owner_id == tid5) begin
						st = nest_write_hold();
					end else begin
						// park own shared holds before contending
						if (sh_cnt[req_tid] != 0) begin
							pk_cnt[req_tid] = sat_sum(pk_cnt[req_tid], sh_cnt[req_tid]);
							sh_cnt[req_tid] = '0;
							reader_cnt--;
						end
						if (owner_id != NO_OWNER) begin
							st = ST_WAIT;
						end else if (reader_cnt != 0) begin
							wr_pending = 1'b1;
							st = ST_WAIT;
						end else begin
							owner_id = tid5;
							wr_cnt = 16'd1;
							wr_pending = 1'b0;
							st = ST_GRANTED;
						end
					end
				end
				K_TRY_LOCK: begin
					if (owner_id == tid5) begin
						st = nest_write_hold();
					end else if (owner_id == NO_OWNER && reader_cnt == 0) begin
						owner_id = tid5;
						wr_cnt = 16'd1;
						wr_pending = 1'b0;
						st = ST_GRANTED;
					end else begin
						st = ST_REFUSED;
					end
				end
				K_UNLOCK:      st = release_write_hold(req_tid);
				K_LOCK_SHARED: st = take_shared_hold(req_tid, 1'b1);
				K_TRY_SHARED:  st = take_shared_hold(req_tid, 1'b0);
				default: begin
					if (owner_id == tid5) begin
						st = release_write_hold(req_tid);
					end else if (sh_cnt[req_tid] == 0) begin
						st = ST_ERROR;
					end else begin
						sh_cnt[req_tid]--;
						if (sh_cnt[req_tid] == 0)
							reader_cnt--;
						st = ST_GRANTED;
					end
				end
			endcase
		end
		r.status  = st;
		r.wdepth  = wr_cnt;
		r.sdepth  = sh_cnt[req_tid];
		r.readers = reader_cnt;
		return r;
	endfunction

	// pick a request that makes sense for the thread's current role
	function automatic logic [2:0] pick_kind_for(input logic [3:0] t);
		int r;
		r = $urandom_range(0, 99);
		if (owner_id == {1'b0, t}) begin
			if (r < 35) return K_UNLOCK;
			if (r < 55) return K_UNLOCK_SHARED;
			if (r < 70) return K_LOCK;
			if (r < 80) return K_TRY_LOCK;
			if (r < 90) return K_LOCK_SHARED;
			return K_TRY_SHARED;
		end
		if (sh_cnt[t] != 0) begin
			if (r < 45) return K_UNLOCK_SHARED;
			if (r < 65) return K_LOCK_SHARED;
			if (r < 75) return K_TRY_SHARED;
			if (r < 90) return K_LOCK;
			return K_TRY_LOCK;
		end
		if (r < 30) return K_LOCK;
		if (r < 50) return K_TRY_LOCK;
		if (r < 80) return K_LOCK_SHARED;
		return K_TRY_SHARED;
	endfunction

	// ---------------------------------------------------------------- drivers

	// offer one request, hold it until taken, then log its expected reply
	task automatic send_request(input logic [2:0] k, input logic [3:0] t);
		int gap;
		if (!tx_quiet) begin
			if (burst_left == 0) begin
				gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 15) : $urandom_range(1, 3);
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
				burst_left = $urandom_range(1, 24);
			end
			burst_left--;
		end
		in_valid  <= 1'b1;
		kind      <= k;
		thread_id <= t;
		do @(posedge clk); while (!in_ready);
		lock_replies_q.push_back(predict_lock_reply(k, t));
	endtask

	// stop offering and wait until every reply is back
	task automatic wait_replies_drained();
		in_valid <= 1'b0;
		burst_left = 0;
		while (lock_replies_q.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic set_recursion_limit(input logic [15:0] v);
		wait_replies_drained();
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= v;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		rec_limit = v;
	endtask

	// receiver: long hold-offs on request, otherwise segments of stall patterns
	always @(posedge clk) begin
		if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else if (rx_quiet) begin
			out_ready <= 1'b1;
		end else begin
			if (rx_seg_left == 0) begin
				rx_mode = $urandom_range(0, 3);
				rx_seg_left = $urandom_range(16, 160);
			end
			rx_seg_left--;
			case (rx_mode)
				0:       out_ready <= 1'b1;
				1:       out_ready <= ($urandom_range(0, 3) != 0);
				2:       out_ready <= ($urandom_range(0, 3) == 0);
				default: out_ready <= ~out_ready;
			endcase
		end
	end

	// ---------------------------------------------------------------- checker

	task automatic report_field(input string name, input int exp, input int act);
		if (exp != act) begin
			if (mismatch_cnt < ERROR_PRINTS)
				$error("%s mismatch: expected %0d, actual %0d", name, exp, act);
			mismatch_cnt++;
		end
	endtask

	// compare each accepted reply with the oldest expectation
	always @(posedge clk) begin
		lock_reply_t exp;
		if (arst_n && out_valid && out_ready) begin
			if (lock_replies_q.size() == 0) begin
				if (mismatch_cnt < ERROR_PRINTS)
					$error("unexpected reply: status %0d write_depth %0d", status, write_depth);
				mismatch_cnt++;
			end else begin
				exp = lock_replies_q.pop_front();
				report_field("status", exp.status, status);
				report_field("write_depth", exp.wdepth, write_depth);
				report_field("shared_depth", exp.sdepth, shared_depth);
				report_field("readers_active", exp.readers, readers_active);
			end
		end
	end

	// watchdog
	always @(posedge clk) begin
		cycle_cnt++;
		if (cycle_cnt > CYCLE_LIMIT) begin
			$display("** recursive_reader_writer_lock: FAILED **");
			$finish;
		end
	end

	// ---------------------------------------------------------------- tests

	// bad unlocks, reserved kinds, writer pending, parking and owner nesting
	task automatic test_directed_requests();
		send_request(K_UNLOCK, 4'd0);
		send_request(K_UNLOCK_SHARED, 4'd0);
		send_request(K_RESERVED_6, 4'd5);
		send_request(K_RESERVED_7, 4'd15);
		send_request(K_TRY_SHARED, 4'd15);
		send_request(K_TRY_LOCK, 4'd0);
		send_request(K_LOCK, 4'd0);
		send_request(K_LOCK_SHARED, 4'd1);
		send_request(K_TRY_SHARED, 4'd1);
		send_request(K_LOCK, 4'd15);
		send_request(K_LOCK_SHARED, 4'd15);
		send_request(K_TRY_LOCK, 4'd15);
		send_request(K_TRY_SHARED, 4'd15);
		send_request(K_TRY_LOCK, 4'd0);
		send_request(K_LOCK, 4'd0);
		send_request(K_LOCK_SHARED, 4'd0);
		send_request(K_UNLOCK_SHARED, 4'd15);
		repeat (3) send_request(K_UNLOCK, 4'd15);
		send_request(K_UNLOCK_SHARED, 4'd15);
		send_request(K_UNLOCK, 4'd0);
		wait_replies_drained();
	endtask

	// build up a shared count and the write depth, park and restore the holds
	task automatic test_count_saturation();
		logic [2:0] nest_kinds [4];
		nest_kinds = '{K_LOCK, K_TRY_LOCK, K_LOCK_SHARED, K_TRY_SHARED};
		tx_quiet = 1'b1;
		rx_quiet = 1'b1;
		set_recursion_limit(16'hFFFF);
		for (int i = 0; i < NEST_RUN; i++)
			send_request(i[0] ? K_LOCK_SHARED : K_TRY_SHARED, 4'd2);
		send_request(K_LOCK_SHARED, 4'd2);
		// park the count while another reader holds off the writer
		send_request(K_LOCK_SHARED, 4'd3);
		send_request(K_LOCK, 4'd2);
		send_request(K_UNLOCK_SHARED, 4'd3);
		send_request(K_TRY_LOCK, 4'd4);
		send_request(K_UNLOCK, 4'd4);
		// park once more so the parked holds add up
		send_request(K_LOCK_SHARED, 4'd2);
		send_request(K_LOCK_SHARED, 4'd3);
		send_request(K_LOCK, 4'd2);
		send_request(K_UNLOCK_SHARED, 4'd3);
		send_request(K_LOCK, 4'd2);
		for (int i = 0; i < NEST_RUN - 1; i++)
			send_request(nest_kinds[i % 4], 4'd2);
		send_request(K_TRY_LOCK, 4'd2);
		for (int i = 0; i < NEST_RUN; i++)
			send_request(i[0] ? K_UNLOCK : K_UNLOCK_SHARED, 4'd2);
		send_request(K_TRY_SHARED, 4'd2);
		for (int i = 0; i < NEST_RUN; i++)
			send_request(K_UNLOCK_SHARED, 4'd2);
		wait_replies_drained();
		tx_quiet = 1'b0;
		rx_quiet = 1'b0;
	endtask

	// nest up to small limits, zero among them, then one past
	task automatic test_recursion_limits();
		logic [15:0] limits [3];
		logic [2:0]  nest_kinds [4];
		logic [3:0]  t;
		limits = '{16'd0, 16'd1, 16'd3};
		nest_kinds = '{K_LOCK, K_TRY_LOCK, K_LOCK_SHARED, K_TRY_SHARED};
		for (int n = 0; n < 3; n++) begin
			set_recursion_limit(limits[n]);
			t = 4'(7 + n);
			send_request(K_LOCK, t);
			for (int i = 1; i < limits[n]; i++)
				send_request(nest_kinds[i % 4], t);
			send_request(nest_kinds[n], t);
			for (int i = 0; i < ((limits[n] == 0) ? 1 : limits[n]); i++)
				send_request(i[0] ? K_UNLOCK_SHARED : K_UNLOCK, t);
		end
	endtask

	// mostly sensible traffic with some noise, contention on a few threads
	task automatic test_random_traffic(input int n, input logic [15:0] limit);
		logic [2:0] k;
		logic [3:0] t;
		set_recursion_limit(limit);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 1) != 0)
				t = 4'($urandom_range(0, 3));
			else
				t = 4'($urandom_range(0, 15));
			if ($urandom_range(0, 99) < 20)
				k = 3'($urandom_range(0, 7));
			else
				k = pick_kind_for(t);
			send_request(k, t);
		end
	endtask

	// hold the receiver off while requests keep coming
	task automatic test_output_backpressure();
		logic [3:0] t;
		wait_replies_drained();
		tx_quiet = 1'b1;
		rx_hold_left = 400;
		for (int i = 0; i < 16; i++) begin
			t = 4'($urandom_range(0, 3));
			send_request(pick_kind_for(t), t);
		end
		tx_quiet = 1'b0;
	endtask

	// sender goes quiet mid-stream until every reply is back
	task automatic test_sender_pause();
		test_random_traffic(200, rec_limit);
		wait_replies_drained();
		test_random_traffic(200, rec_limit);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed_requests();
		test_count_saturation();
		test_recursion_limits();
		test_random_traffic(300, 16'hFFFF);
		test_output_backpressure();
		test_random_traffic(350, 16'd2);
		test_random_traffic(350, 16'd1);
		test_random_traffic(350, 16'd0);
		test_sender_pause();
		test_random_traffic(300, 16'($urandom_range(1, 6)));
		wait_replies_drained();
		repeat (10) @(posedge clk);
		if (mismatch_cnt == 0 && lock_replies_q.size() == 0)
			$display("** recursive_reader_writer_lock: PASSED **");
		else
			$display("** recursive_reader_writer_lock: FAILED **");
		$finish;
	end

endmodule
